// ----- hw/rtl/fan_tach_period_to_rpm_assert.svh -----
// Assertion macros for the fan tachometer RTL.
`ifndef FAN_TACH_PERIOD_TO_RPM_ASSERT_SVH
`define FAN_TACH_PERIOD_TO_RPM_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FTR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FTR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ftr_pkg.sv -----
// Package: types, codes and reset constants of the fan tachometer.
`default_nettype none

package ftr_pkg;

    localparam int NUM_CHANNELS_DEF = 2;
    localparam int PERIOD_W         = 16;
    localparam int COUNT_W          = 8;
    localparam int FACTOR_W         = 24;
    localparam int RPM_W            = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 24;
    localparam int DIV_STEPS        = FACTOR_W;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

    localparam logic [PERIOD_W-1:0] WRAP_COUNT_RST    = 16'd50000;
    localparam logic [PERIOD_W-1:0] PERIOD_LO_RST     = 16'd300;
    localparam logic [PERIOD_W-1:0] PERIOD_HI_RST     = 16'd30000;
    localparam logic [COUNT_W-1:0]  TIMEOUT_LIMIT_RST = 8'd2;
    localparam logic [FACTOR_W-1:0] RPM_FACTOR_RST    = 24'd6000000;

    typedef enum logic [1:0] {
        CMD_CAPTURE = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RESET   = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WRAP_COUNT    = 3'd0,
        REG_PERIOD_LO     = 3'd1,
        REG_PERIOD_HI     = 3'd2,
        REG_TIMEOUT_LIMIT = 3'd3,
        REG_RPM_FACTOR    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] wrap_count;
        logic [PERIOD_W-1:0] period_lo;
        logic [PERIOD_W-1:0] period_hi;
        logic [COUNT_W-1:0]  timeout_limit;
        logic [FACTOR_W-1:0] rpm_factor;
    } cfg_t;

    typedef struct packed {
        logic                stopped;
        logic [PERIOD_W-1:0] period;
    } chan_view_t;

    function automatic logic in_window(input logic [PERIOD_W-1:0] p,
                                       input logic [PERIOD_W-1:0] lo,
                                       input logic [PERIOD_W-1:0] hi);
        return (p != '0) && (p >= lo) && (p <= hi);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ftr_chan_state.sv -----
// Per-channel tachometer state: last capture, stored period, timeout count.
`default_nettype none

module ftr_chan_state
    import ftr_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cfg_t                cfg,
    input  wire logic                wr_en,
    input  wire logic [1:0]          wr_cmd,
    input  wire logic                wr_channel,
    input  wire logic [PERIOD_W-1:0] wr_capture,
    input  wire logic                rd_channel,
    output chan_view_t               view
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [PERIOD_W-1:0] last_reg   [NUM_CHANNELS];
    logic [PERIOD_W-1:0] last_next  [NUM_CHANNELS];
    logic [PERIOD_W-1:0] period_reg [NUM_CHANNELS];
    logic [PERIOD_W-1:0] period_next[NUM_CHANNELS];
    logic [COUNT_W-1:0]  count_reg  [NUM_CHANNELS];
    logic [COUNT_W-1:0]  count_next [NUM_CHANNELS];

    always_comb begin
        logic [PERIOD_W-1:0] diff;
        logic                sel;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_next[i]   = last_reg[i];
            period_next[i] = period_reg[i];
            count_next[i]  = count_reg[i];
            sel  = (IDX_W'(wr_channel) == IDX_W'(i));
            // wrap at the counter period, modulo 2^16 like the counter itself
            if (wr_capture >= last_reg[i]) begin
                diff = wr_capture - last_reg[i];
            end else begin
                diff = cfg.wrap_count - last_reg[i] + wr_capture;
            end
            if (wr_en) begin
                unique case (cmd_t'(wr_cmd))
                    CMD_CAPTURE: begin
                        if (sel) begin
                            last_next[i] = wr_capture;
                            if (in_window(diff, cfg.period_lo, cfg.period_hi)) begin
                                if (count_reg[i] < cfg.timeout_limit) begin
                                    period_next[i] = diff;
                                end
                                count_next[i] = '0;
                            end
                        end
                    end
                    CMD_TICK: begin
                        if (count_reg[i] < cfg.timeout_limit) begin
                            count_next[i] = count_reg[i] + 1'b1;
                        end
                    end
                    CMD_RESET: begin
                        if (sel) begin
                            period_next[i] = '0;
                            count_next[i]  = cfg.timeout_limit;
                        end
                    end
                    CMD_READ: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (!aresetn) begin
                last_reg[i]   <= '0;
                period_reg[i] <= '0;
                count_reg[i]  <= TIMEOUT_LIMIT_RST;
            end else begin
                last_reg[i]   <= last_next[i];
                period_reg[i] <= period_next[i];
                count_reg[i]  <= count_next[i];
            end
        end
    end

    // Report view of the addressed channel; a channel beyond the count reads as stopped.
    always_comb begin
        logic found;
        found        = 1'b0;
        view.stopped = 1'b1;
        view.period  = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (IDX_W'(rd_channel) == IDX_W'(i)) begin
                found        = 1'b1;
                view.period  = period_reg[i];
                view.stopped = (count_reg[i] >= cfg.timeout_limit) ||
                               !in_window(period_reg[i], cfg.period_lo, cfg.period_hi);
            end
        end
        if (!found) begin
            view.stopped = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ftr_serial_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module ftr_serial_div
    import ftr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [FACTOR_W-1:0] dividend,
    input  wire logic [PERIOD_W-1:0] divisor,
    output logic                     busy,
    output logic                     done,
    output logic [FACTOR_W-1:0]      quotient
);

    logic [FACTOR_W-1:0]  quo_reg, quo_next;
    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [PERIOD_W-1:0]  dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;

    logic [PERIOD_W:0] rem_shift;
    logic [PERIOD_W:0] rem_sub;
    logic              fits;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[FACTOR_W-1]};
        rem_sub   = rem_shift - {1'b0, dsr_reg};
        fits      = (rem_shift >= {1'b0, dsr_reg});
        rem_next  = fits ? rem_sub[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
        quo_next  = {quo_reg[FACTOR_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/fan_tach_period_to_rpm.sv -----
// Each item goes through a channel lookup, then the 24-step serial divider unless the channel
// is stopped; a new item is accepted only after the previous one has left the sequencer.
// A new item is taken while the previous result still waits in the output register.
// Reset (aresetn low, synchronous) restores register defaults, clears captures and
// periods, and loads every timeout count with the default limit; no memory sweep.
`default_nettype none

module fan_tach_period_to_rpm
    import ftr_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // item input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_cmd,
    input  wire logic                  s_channel,
    input  wire logic [PERIOD_W-1:0]   s_capture_value,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [RPM_W-1:0]           m_rpm,
    output logic                       m_fan_stopped
);

    `include "fan_tach_period_to_rpm_assert.svh"

    // Sequencer: idle -> look up channel -> divide (skipped for a stopped channel) -> hand result to output.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    cfg_t       cfg_reg;
    chan_view_t view;
    logic       s_xfer;
    logic       m_free;
    logic       ch_reg;
    logic       stopped_reg, stopped_next;
    logic       div_start, div_busy, div_done;
    logic [FACTOR_W-1:0] div_quo;
    logic [RPM_W-1:0]    rpm_sat;
    logic                m_valid_reg;
    logic [RPM_W-1:0]    m_rpm_reg;
    logic                m_stopped_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign m_free  = !m_valid_reg || m_ready;

    // Configuration registers; an index beyond the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wrap_count    <= WRAP_COUNT_RST;
            cfg_reg.period_lo     <= PERIOD_LO_RST;
            cfg_reg.period_hi     <= PERIOD_HI_RST;
            cfg_reg.timeout_limit <= TIMEOUT_LIMIT_RST;
            cfg_reg.rpm_factor    <= RPM_FACTOR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WRAP_COUNT:    cfg_reg.wrap_count    <= cfg_wdata[PERIOD_W-1:0];
                REG_PERIOD_LO:     cfg_reg.period_lo     <= cfg_wdata[PERIOD_W-1:0];
                REG_PERIOD_HI:     cfg_reg.period_hi     <= cfg_wdata[PERIOD_W-1:0];
                REG_TIMEOUT_LIMIT: cfg_reg.timeout_limit <= cfg_wdata[COUNT_W-1:0];
                REG_RPM_FACTOR:    cfg_reg.rpm_factor    <= cfg_wdata[FACTOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Channel state updates at the input transfer edge itself.
    ftr_chan_state #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_chan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .wr_en      (s_xfer),
        .wr_cmd     (s_cmd),
        .wr_channel (s_channel),
        .wr_capture (s_capture_value),
        .rd_channel (ch_reg),
        .view       (view)
    );

    // rpm = factor / period, one quotient bit per cycle
    ftr_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cfg_reg.rpm_factor),
        .divisor  (view.period),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Saturate the quotient to the result width.
    assign rpm_sat = (div_quo[FACTOR_W-1:RPM_W] != '0) ? {RPM_W{1'b1}} : div_quo[RPM_W-1:0];

    always_comb begin
        state_next   = state_reg;
        stopped_next = stopped_reg;
        div_start    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                // stopped channels skip the divide
                stopped_next = view.stopped;
                if (view.stopped) begin
                    state_next = ST_FIN;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (m_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            ch_reg <= s_channel;
        end
        stopped_reg <= stopped_next;
    end

    // Output register: load from the finish state, drop valid after the transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && m_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && m_free) begin
            m_rpm_reg     <= stopped_reg ? '0 : rpm_sat;
            m_stopped_reg <= stopped_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_rpm         = m_rpm_reg;
    assign m_fan_stopped = m_stopped_reg;

    `FTR_ASSERT_NOW(a_stopped_zero_rpm, aclk, aresetn, m_valid && m_fan_stopped, m_rpm == '0,
        "stopped fan reported with nonzero rpm")
    `FTR_ASSERT_NOW(a_div_only_in_div, aclk, aresetn, div_busy, state_reg == ST_DIV,
        "divider running outside the divide state")
    `FTR_ASSERT_NEXT(a_xfer_to_look, aclk, aresetn, s_xfer, state_reg == ST_LOOK && !s_ready,
        "input transfer not followed by channel lookup")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the two-channel fan tachometer speed block.
`default_nettype none

module tb_top;
    import ftr_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 7;
    // Nothing may be accepted for this many cycles before the run is declared hung.
    // The worst legal quiet spell is the receiver hold-off plus a full divide.
    localparam int WATCHDOG_LIMIT = 4000;
    // Settle time once every expected result has been checked.
    localparam int SETTLE_CYCLES  = 40;
    localparam int BACKLOG_HOLD   = 300;
    localparam int NUM_FANS       = NUM_CHANNELS_DEF;
    // Index past the last register: the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [RPM_W-1:0] rpm;
        logic             stopped;
    } speed_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_cmd           = CMD_READ;
    logic                  s_channel       = 1'b0;
    logic [PERIOD_W-1:0]   s_capture_value = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [RPM_W-1:0]      m_rpm;
    logic                  m_fan_stopped;

    always #HALF_PERIOD aclk = ~aclk;

    fan_tach_period_to_rpm #(
        .NUM_CHANNELS(NUM_FANS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_channel      (s_channel),
        .s_capture_value(s_capture_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rpm          (m_rpm),
        .m_fan_stopped  (m_fan_stopped)
    );

    // ------------------------------------------------------------------
    // Run bookkeeping.
    // ------------------------------------------------------------------
    speed_t speed_expect[$];
    int     errors          = 0;
    int     items_sent      = 0;
    int     results_checked = 0;
    int     reg_writes      = 0;
    int     idle_pct        = 25;   // shared by sender gaps and receiver stalls
    int     backlog_req     = 0;    // bumped by a test to ask for a long hold-off
    int     backlog_ack     = 0;
    int     hold_left       = 0;
    int     quiet_cycles    = 0;

    // ------------------------------------------------------------------
    // Speed predictor: its own copy of the registers and per-fan state.
    // ------------------------------------------------------------------
    logic [PERIOD_W-1:0] wrap_cnt;
    logic [PERIOD_W-1:0] min_per;
    logic [PERIOD_W-1:0] max_per;
    logic [COUNT_W-1:0]  to_limit;
    logic [FACTOR_W-1:0] rpm_fac;
    logic [PERIOD_W-1:0] last_cap   [NUM_FANS];
    logic [PERIOD_W-1:0] period_q   [NUM_FANS];
    logic [COUNT_W-1:0]  idle_ticks [NUM_FANS];

    function automatic void restore_defaults();
        wrap_cnt = WRAP_COUNT_RST;
        min_per  = PERIOD_LO_RST;
        max_per  = PERIOD_HI_RST;
        to_limit = TIMEOUT_LIMIT_RST;
        rpm_fac  = RPM_FACTOR_RST;
        for (int i = 0; i < NUM_FANS; i++) begin
            last_cap[i]   = '0;
            period_q[i]   = '0;
            idle_ticks[i] = TIMEOUT_LIMIT_RST;
        end
    endfunction

    // A zero period never counts, so the divide below never sees zero.
    function automatic logic period_ok(logic [PERIOD_W-1:0] p);
        return (p != '0) && (p >= min_per) && (p <= max_per);
    endfunction

    // Apply one item to the predicted state and return the speed it reports.
    function automatic speed_t advance_tach(cmd_t c, logic ch, logic [PERIOD_W-1:0] cap);
        logic [PERIOD_W-1:0] diff;
        logic [FACTOR_W-1:0] quot;
        speed_t              r;
        case (c)
            CMD_CAPTURE: begin
                // Below the last capture the counter wrapped at wrap_cnt; keep 16 bits.
                diff = (cap >= last_cap[ch]) ? cap - last_cap[ch]
                                             : wrap_cnt - last_cap[ch] + cap;
                last_cap[ch] = cap;
                if (period_ok(diff)) begin
                    if (idle_ticks[ch] < to_limit)
                        period_q[ch] = diff;
                    idle_ticks[ch] = '0;
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < NUM_FANS; i++)
                    if (idle_ticks[i] < to_limit)
                        idle_ticks[i] = idle_ticks[i] + 1'b1;
            end
            CMD_RESET: begin
                period_q[ch]   = '0;
                idle_ticks[ch] = to_limit;
            end
            default: ;
        endcase
        if (idle_ticks[ch] >= to_limit || !period_ok(period_q[ch])) begin
            r.rpm     = '0;
            r.stopped = 1'b1;
        end else begin
            quot      = rpm_fac / period_q[ch];
            r.rpm     = (quot > 24'h00FFFF) ? 16'hFFFF : quot[RPM_W-1:0];
            r.stopped = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (backlog_req != backlog_ack) begin
            backlog_ack <= backlog_req;
            hold_left   <= BACKLOG_HOLD;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each transfer with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_result
        speed_t want;
        if (aresetn && m_valid && m_ready) begin
            if (speed_expect.size() == 0) begin
                $error("result with nothing expected: rpm=%0d fan_stopped=%0b",
                       m_rpm, m_fan_stopped);
                errors++;
            end else begin
                want = speed_expect.pop_front();
                results_checked++;
                if (m_rpm !== want.rpm) begin
                    $error("rpm: expected %0d, got %0d", want.rpm, m_rpm);
                    errors++;
                end
                if (m_fan_stopped !== want.stopped) begin
                    $error("fan_stopped: expected %0b, got %0b", want.stopped, m_fan_stopped);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, speed_expect.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers.
    // ------------------------------------------------------------------

    // Offer one item; hold valid and payload until the transfer, then predict.
    // Valid is left high so a following item goes out back to back.
    task automatic send_item(cmd_t c, logic ch, logic [PERIOD_W-1:0] cap);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= c;
        s_channel       <= ch;
        s_capture_value <= cap;
        do @(posedge aclk); while (!s_ready);
        speed_expect.push_back(advance_tach(c, ch, cap));
        items_sent++;
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (speed_expect.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        reg_writes++;
        case (idx)
            REG_WRAP_COUNT:    wrap_cnt = val[PERIOD_W-1:0];
            REG_PERIOD_LO:     min_per  = val[PERIOD_W-1:0];
            REG_PERIOD_HI:     max_per  = val[PERIOD_W-1:0];
            REG_TIMEOUT_LIMIT: to_limit = val[COUNT_W-1:0];
            REG_RPM_FACTOR:    rpm_fac  = val[FACTOR_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_settings(int wrap, int lo, int hi, int lim, int fac);
        drain_and_settle();
        write_reg(REG_WRAP_COUNT, CFG_DATA_W'(wrap));
        write_reg(REG_PERIOD_LO, CFG_DATA_W'(lo));
        write_reg(REG_PERIOD_HI, CFG_DATA_W'(hi));
        write_reg(REG_TIMEOUT_LIMIT, CFG_DATA_W'(lim));
        write_reg(REG_RPM_FACTOR, CFG_DATA_W'(fac));
    endtask

    // Mostly well-formed captures: the next edge lands one in-window period after
    // the last one, wrapping at wrap_cnt. The rest is noise, ticks, resets, reads.
    task automatic random_item();
        int                  r;
        int                  lo;
        int                  hi;
        int                  nxt;
        logic                ch;
        logic [PERIOD_W-1:0] cap;
        ch  = 1'($urandom_range(0, 1));
        r   = $urandom_range(0, 99);
        cap = PERIOD_W'($urandom);
        if (r < 58) begin
            lo = (min_per == '0) ? 1 : int'(min_per);
            hi = int'(max_per);
            if (hi > int'(wrap_cnt) - 1)
                hi = int'(wrap_cnt) - 1;
            if (lo <= hi && last_cap[ch] < wrap_cnt) begin
                nxt = int'(last_cap[ch]) + int'($urandom_range(hi, lo));
                if (nxt >= int'(wrap_cnt))
                    nxt -= int'(wrap_cnt);
                cap = nxt[PERIOD_W-1:0];
            end
            send_item(CMD_CAPTURE, ch, cap);
        end else if (r < 62) begin
            // repeat the last edge: zero difference
            send_item(CMD_CAPTURE, ch, last_cap[ch]);
        end else if (r < 67) begin
            send_item(CMD_CAPTURE, ch, cap);
        end else if (r < 79) begin
            send_item(CMD_TICK, ch, cap);
        end else if (r < 84) begin
            send_item(CMD_RESET, ch, cap);
        end else begin
            send_item(CMD_READ, ch, cap);
        end
    endtask

    task automatic run_random(int count);
        repeat (count) random_item();
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Walk the reset defaults through every command and the capture corner cases.
    task automatic test_power_on_directed();
        send_item(CMD_READ,    1'b0, 16'h0000);  // stopped out of reset
        send_item(CMD_READ,    1'b1, 16'hFFFF);
        send_item(CMD_CAPTURE, 1'b0, 16'd1000);  // clears timeout, no period stored
        send_item(CMD_CAPTURE, 1'b0, 16'd2000);  // first stored period
        send_item(CMD_CAPTURE, 1'b0, 16'd1500);  // below last: wrapped, out of window
        send_item(CMD_CAPTURE, 1'b0, 16'd1800);  // exactly the minimum period
        send_item(CMD_CAPTURE, 1'b0, 16'd31800); // exactly the maximum period
        send_item(CMD_CAPTURE, 1'b0, 16'd61801); // one past maximum, above wrap
        send_item(CMD_CAPTURE, 1'b0, 16'd0);     // last capture above wrap
        send_item(CMD_CAPTURE, 1'b0, 16'd299);   // one below minimum
        send_item(CMD_TICK,    1'b0, 16'h5A5A);  // ch1 already at limit: saturate
        send_item(CMD_READ,    1'b0, 16'hA5A5);
        send_item(CMD_TICK,    1'b1, 16'hFFFF);  // ch0 times out
        send_item(CMD_READ,    1'b0, 16'h0000);
        send_item(CMD_CAPTURE, 1'b0, 16'd600);   // timed out: count cleared, period kept
        send_item(CMD_CAPTURE, 1'b0, 16'd601);   // tiny difference
        send_item(CMD_RESET,   1'b0, 16'hFFFF);
        send_item(CMD_READ,    1'b0, 16'h0001);
        send_item(CMD_CAPTURE, 1'b1, 16'hFFFF);
        send_item(CMD_CAPTURE, 1'b1, 16'd12000); // wrap from above wrap_count
        send_item(CMD_CAPTURE, 1'b1, 16'd12300);
        send_item(CMD_CAPTURE, 1'b1, 16'd12600);
        send_item(CMD_RESET,   1'b1, 16'hA5A5);
        send_item(CMD_READ,    1'b1, 16'h5A5A);
    endtask

    // Sweep register settings, the extremes among them, with random traffic each.
    task automatic test_register_extremes();
        // widest window, largest factor: rpm saturates on short periods
        apply_settings(65535, 1, 65535, 255, 24'hFFFFFF);
        run_random(70);
        // smallest everything; factor 1 gives rpm 1 on a running fan
        apply_settings(1, 1, 1, 1, 1);
        run_random(70);
        // empty window: min above max, no capture counts
        apply_settings(40000, 5000, 100, 3, 6000000);
        write_reg(REG_SPARE, 24'hFFFFFF);
        run_random(70);
        // zero minimum: a zero difference must still be rejected
        apply_settings(20000, 0, 2000, 4, 24'h800000);
        run_random(70);
        // zero limit: every channel reads as stopped
        apply_settings(30000, 200, 20000, 0, 24'h123456);
        run_random(70);
        // short wrap with a narrow window: most captures wrap
        apply_settings(1000, 50, 900, 2, 24'h555555);
        run_random(70);
    endtask

    // Lower the limit below counts already reached: ticks must leave them alone.
    task automatic test_limit_lowered();
        apply_settings(50000, 300, 30000, 200, 6000000);
        run_random(40);
        repeat (6) send_item(CMD_TICK, 1'($urandom_range(0, 1)), PERIOD_W'($urandom));
        drain_and_settle();
        write_reg(REG_TIMEOUT_LIMIT, 24'd1);
        run_random(40);
    endtask

    // Hold the receiver off while items keep coming so the block fills and stalls.
    task automatic test_output_backlog();
        apply_settings(50000, 300, 30000, 2, 6000000);
        idle_pct    = 0;
        backlog_req <= backlog_req + 1;
        run_random(40);
        idle_pct = 25;
    endtask

    // Back-to-back traffic with no gaps on either side.
    task automatic test_steady_stream();
        idle_pct = 0;
        run_random(200);
        idle_pct = 25;
    endtask

    // Long mixed run at the reset defaults.
    task automatic test_mixed_traffic();
        apply_settings(WRAP_COUNT_RST, PERIOD_LO_RST, PERIOD_HI_RST,
                       TIMEOUT_LIMIT_RST, RPM_FACTOR_RST);
        run_random(380);
    endtask

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    initial begin
        restore_defaults();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_power_on_directed();
        test_register_extremes();
        test_limit_lowered();
        test_output_backlog();
        test_steady_stream();
        test_mixed_traffic();

        drain_and_settle();
        $display("tb_top: %0d items sent, %0d results checked, %0d register writes",
                 items_sent, results_checked, reg_writes);
        $display("tb_top: covered capture windows, wraps, timeouts, resets, back-pressure");
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ftr_pkg.sv
hw/rtl/ftr_chan_state.sv
hw/rtl/ftr_serial_div.sv
hw/rtl/fan_tach_period_to_rpm.sv
tb/tb_top.sv
